[src/ordered_array_list_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ordered array list
// Clocked concurrent checks on clk with the asynchronous reset arst_n; they
// expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_LIST_TOP_MACROS_SVH
`define ORDERED_ARRAY_LIST_TOP_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define OAL_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error("ordered array list check failed");

// The consequent must hold in the cycle after the antecedent.
`define OAL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error("ordered array list check failed");

`else

`define OAL_ASSERT_SAME(label, ante, cons)
`define OAL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[src/oal_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered array list package
// Sizes, request and result beat types and the control struct shared by the
// list cells, the search groups and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package oal_pkg;

	localparam int LIST_DEPTH = 64;
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	// Wide enough for any position, count or cell index plus one.
	localparam int CMP_W      = CNT_W + 8;

	localparam int GRP        = 8;
	localparam int GRP_W      = 3;
	localparam int NUM_GRP    = (LIST_DEPTH + GRP - 1) / GRP;
	localparam int NG_W       = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
	localparam int PAD_DEPTH  = NUM_GRP * GRP;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_GET    = 2'd2,
		REQ_LOCATE = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_INSERT,
		OP_DELETE,
		OP_GET,
		OP_LOCATE
	} cell_op_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [6:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic signed [31:0] read_value;
		logic [6:0]         found_position;
		logic [6:0]         list_length;
	} rsp_t;

	typedef struct packed {
		logic             take;
		cell_op_t         op;
		logic [6:0]       position;
		logic [31:0]      value;
		logic [CNT_W-1:0] count;
	} cell_ctrl_t;

	typedef struct packed {
		logic             any;
		logic [GRP_W-1:0] idx;
		logic [31:0]      data;
	} grp_res_t;

	// Result fields are seven bits wide; larger values wrap.
	function automatic logic [6:0] to_f7(input logic [CMP_W-1:0] v);
		return v[6:0];
	endfunction

endpackage

`default_nettype wire

[src/oal_cell.sv]
// ----------------------------------------------------------------------------
// Ordered array list cell
// Holds one list entry, shifts with its neighbors on insert and delete, and
// registers a hit flag for get and locate.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [oal_pkg::IDX_W-1:0]   cell_idx,
	input  oal_pkg::cell_ctrl_t         ctrl,
	input  logic [31:0]                 up_in,
	input  logic [31:0]                 dn_in,
	output logic [31:0]                 entry,
	output logic                        hit,
	output logic [31:0]                 hit_data
);

	logic [31:0]                 entry_q;
	logic                        hit_s1;
	logic [oal_pkg::CMP_W-1:0]   kk;
	logic [oal_pkg::CMP_W-1:0]   pp;
	logic [oal_pkg::CMP_W-1:0]   cc;
	logic                        at_pos;
	logic                        above_pos;
	logic                        hit_d;

	always_comb begin
		kk        = oal_pkg::CMP_W'(cell_idx);
		pp        = oal_pkg::CMP_W'(ctrl.position);
		cc        = oal_pkg::CMP_W'(ctrl.count);
		at_pos    = (kk + oal_pkg::CMP_W'(1)) == pp;
		above_pos = kk >= pp;
		unique case (ctrl.op)
			oal_pkg::OP_GET:    hit_d = at_pos;
			oal_pkg::OP_LOCATE: hit_d = (entry_q == ctrl.value) && (kk < cc);
			default:            hit_d = 1'b0;
		endcase
	end

	// Entries above the list are always zero, so the whole upper part can shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctrl.take) begin
			unique case (ctrl.op)
				oal_pkg::OP_INSERT: begin
					if (at_pos) begin
						entry_q <= ctrl.value;
					end else if (above_pos) begin
						entry_q <= up_in;
					end
				end
				oal_pkg::OP_DELETE: begin
					if (at_pos || above_pos) begin
						entry_q <= dn_in;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			hit_s1 <= hit_d;
		end
	end

	assign entry    = entry_q;
	assign hit      = hit_s1;
	assign hit_data = hit_s1 ? entry_q : '0;

endmodule

`default_nettype wire

[src/oal_group.sv]
// ----------------------------------------------------------------------------
// Ordered array list search group
// Finds the first flagged cell among eight and merges their masked data into
// one registered group result.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_group (
	input  logic                    clk,
	input  logic [oal_pkg::GRP-1:0] flags,
	input  logic [31:0]             datas [oal_pkg::GRP],
	output oal_pkg::grp_res_t       res
);

	oal_pkg::grp_res_t res_d;
	oal_pkg::grp_res_t res_s2;

	always_comb begin
		res_d = '0;
		// Walking down leaves the lowest flagged cell selected.
		for (int j = oal_pkg::GRP - 1; j >= 0; j--) begin
			if (flags[j]) begin
				res_d.any = 1'b1;
				res_d.idx = oal_pkg::GRP_W'(j);
			end
			res_d.data = res_d.data | datas[j];
		end
	end

	always_ff @(posedge clk) begin
		res_s2 <= res_d;
	end

	assign res = res_s2;

endmodule

`default_nettype wire

[src/ordered_array_list_top.sv]
// ----------------------------------------------------------------------------
// Ordered array list
// A row of list cells with shift-on-insert/delete and a registered search
// tree for get and locate.
// ----------------------------------------------------------------------------
// Usage: present a request beat on req and raise start; it is taken at the
// rising edge where start is high and busy is low. Insert places req.value at
// the 1-based req.position, delete removes that position, get reads it, and
// locate reports the first position holding req.value.
// Each request gives one result beat on rsp, marked by done for exactly one
// cycle, after the cell flag, group and result registers. The receiver cannot
// stall. New requests wait for the group stage to clear. Cells shift or flag
// entries in the accept cycle, then a two-level registered search tree (groups
// of eight cells, then across groups) picks the hit before the result register.
// busy is high while a request is in the cell flag or group stage.
// Reset clears every entry and the length to zero and drops busy and done.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_array_list_top_macros.svh"

module ordered_array_list_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  oal_pkg::req_t req,
	output logic          done,
	output oal_pkg::rsp_t rsp
);

	logic                           take;
	logic [oal_pkg::CNT_W-1:0]      count_q;
	logic [oal_pkg::CMP_W-1:0]      pp;
	logic [oal_pkg::CMP_W-1:0]      cc;
	logic                           in_range;
	logic                           ins_ok;
	oal_pkg::cell_op_t              op_d;
	logic                           ok_d;
	logic [oal_pkg::CNT_W-1:0]      count_d;
	oal_pkg::cell_ctrl_t            ctrl;

	logic [31:0]                    entry_w [oal_pkg::LIST_DEPTH];
	logic [oal_pkg::PAD_DEPTH-1:0]  hit_w;
	logic [31:0]                    data_w  [oal_pkg::PAD_DEPTH];
	oal_pkg::grp_res_t              grp_w   [oal_pkg::NUM_GRP];

	logic                           v_s1;
	oal_pkg::req_kind_t             kind_s1;
	logic                           ok_s1;
	logic [oal_pkg::CNT_W-1:0]      len_s1;
	logic                           v_s2;
	oal_pkg::req_kind_t             kind_s2;
	logic                           ok_s2;
	logic [oal_pkg::CNT_W-1:0]      len_s2;

	logic                           sel_any;
	logic [oal_pkg::NG_W-1:0]       sel_grp;
	logic [oal_pkg::GRP_W-1:0]      sel_idx;
	logic [31:0]                    sel_data;
	logic [oal_pkg::CMP_W-1:0]      sel_pos;
	oal_pkg::rsp_t                  rsp_d;
	oal_pkg::rsp_t                  rsp_q;
	logic                           done_q;

	assign take = start && !busy;

	always_comb begin
		pp       = oal_pkg::CMP_W'(req.position);
		cc       = oal_pkg::CMP_W'(count_q);
		in_range = (pp != '0) && (pp <= cc);
		ins_ok   = (pp != '0) && (pp <= cc + oal_pkg::CMP_W'(1))
		           && (cc != oal_pkg::CMP_W'(oal_pkg::LIST_DEPTH));
		op_d     = oal_pkg::OP_NOP;
		ok_d     = 1'b0;
		count_d  = count_q;
		unique case (oal_pkg::req_kind_t'(req.req_type))
			oal_pkg::REQ_INSERT: begin
				ok_d = ins_ok;
				if (ins_ok) begin
					op_d    = oal_pkg::OP_INSERT;
					count_d = count_q + oal_pkg::CNT_W'(1);
				end
			end
			oal_pkg::REQ_DELETE: begin
				ok_d = in_range;
				if (in_range) begin
					op_d    = oal_pkg::OP_DELETE;
					count_d = count_q - oal_pkg::CNT_W'(1);
				end
			end
			oal_pkg::REQ_GET: begin
				ok_d = in_range;
				if (in_range) begin
					op_d = oal_pkg::OP_GET;
				end
			end
			oal_pkg::REQ_LOCATE: begin
				op_d = oal_pkg::OP_LOCATE;
			end
		endcase
		ctrl.take     = take;
		ctrl.op       = op_d;
		ctrl.position = req.position;
		ctrl.value    = req.value;
		ctrl.count    = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (take) begin
			count_q <= count_d;
		end
	end

	for (genvar i = 0; i < oal_pkg::PAD_DEPTH; i++) begin : g_cell
		if (i < oal_pkg::LIST_DEPTH) begin : g_real
			logic [31:0] up_w;
			logic [31:0] dn_w;
			if (i == 0) begin : g_first
				assign up_w = '0;
			end else begin : g_mid_up
				assign up_w = entry_w[i-1];
			end
			if (i == oal_pkg::LIST_DEPTH - 1) begin : g_last
				assign dn_w = '0;
			end else begin : g_mid_dn
				assign dn_w = entry_w[i+1];
			end
			oal_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cell_idx (oal_pkg::IDX_W'(i)),
				.ctrl     (ctrl),
				.up_in    (up_w),
				.dn_in    (dn_w),
				.entry    (entry_w[i]),
				.hit      (hit_w[i]),
				.hit_data (data_w[i])
			);
		end else begin : g_pad
			assign hit_w[i]  = 1'b0;
			assign data_w[i] = '0;
		end
	end

	for (genvar g = 0; g < oal_pkg::NUM_GRP; g++) begin : g_grp
		oal_group u_group (
			.clk   (clk),
			.flags (hit_w[g*oal_pkg::GRP +: oal_pkg::GRP]),
			.datas (data_w[g*oal_pkg::GRP +: oal_pkg::GRP]),
			.res   (grp_w[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1 <= oal_pkg::req_kind_t'(req.req_type);
			ok_s1   <= ok_d;
			len_s1  <= count_d;
		end
		kind_s2 <= kind_s1;
		ok_s2   <= ok_s1;
		len_s2  <= len_s1;
	end

	always_comb begin
		sel_any  = 1'b0;
		sel_grp  = '0;
		sel_idx  = '0;
		sel_data = '0;
		// Lowest group with a hit wins.
		for (int g = oal_pkg::NUM_GRP - 1; g >= 0; g--) begin
			if (grp_w[g].any) begin
				sel_any = 1'b1;
				sel_grp = oal_pkg::NG_W'(g);
				sel_idx = grp_w[g].idx;
			end
			sel_data = sel_data | grp_w[g].data;
		end
		sel_pos = oal_pkg::CMP_W'({sel_grp, sel_idx}) + oal_pkg::CMP_W'(1);

		rsp_d                = '0;
		rsp_d.list_length    = oal_pkg::to_f7(oal_pkg::CMP_W'(len_s2));
		unique case (kind_s2)
			oal_pkg::REQ_GET: begin
				rsp_d.ok         = ok_s2;
				rsp_d.read_value = ok_s2 ? sel_data : '0;
			end
			oal_pkg::REQ_LOCATE: begin
				rsp_d.ok             = sel_any;
				rsp_d.found_position = sel_any ? oal_pkg::to_f7(sel_pos) : '0;
			end
			default: begin
				rsp_d.ok = ok_s2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			rsp_q  <= '0;
		end else begin
			done_q <= v_s2;
			if (v_s2) begin
				rsp_q <= rsp_d;
			end
		end
	end

	assign busy = v_s1 || v_s2;
	assign done = done_q;
	assign rsp  = rsp_q;

	// A taken request keeps the block busy through the search stages.
	`OAL_ASSERT_NEXT(a_take_busy, take, busy && !done)
	// A result beat leaves the search stages empty.
	`OAL_ASSERT_SAME(a_done_idle, done, !busy)
	// The length never exceeds the store.
	`OAL_ASSERT_SAME(a_count_max, 1'b1, count_q <= oal_pkg::CNT_W'(oal_pkg::LIST_DEPTH))
	// Get data and a locate position never appear in the same beat.
	`OAL_ASSERT_SAME(a_rsp_excl, done, (rsp.found_position == '0) || (rsp.read_value == '0))

endmodule

`default_nettype wire

[sim/tb_ordered_array_list_top.sv]
// ----------------------------------------------------------------------------
// Ordered array list testbench
// Drives insert, delete, get and locate requests through the start/busy
// handshake. A scoreboard keeps its own copy of the list to predict every
// result beat, and each beat is checked field by field in arrival order.
// A directed opening covers the edge cases. Random phases follow that fill
// the list, empty it and mix requests, with varying sender idle time.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ordered_array_list_top;

	localparam int STALL_LIMIT  = 1000;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 78;
	localparam int MAX_PRINTS   = 40;

	logic           clk    = 1'b0;
	logic           arst_n = 1'b0;
	logic           start  = 1'b0;
	oal_pkg::req_t  req    = '0;
	logic           busy;
	logic           done;
	oal_pkg::rsp_t  rsp;
	int             stall_cycles = 0;

	always #2 clk = ~clk;

	ordered_array_list_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// Shadow copy of the list; predicts one result beat per accepted request.
	class list_scoreboard;
		logic [31:0]   store [oal_pkg::LIST_DEPTH];
		int            len;
		oal_pkg::rsp_t expected_q [$];
		int            errors;

		function new();
			foreach (store[i]) store[i] = '0;
			len    = 0;
			errors = 0;
		endfunction

		function int list_len();
			return len;
		endfunction

		function logic [31:0] entry_at(int idx);
			return store[idx];
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string msg);
			if (errors < MAX_PRINTS)
				$display("%0t ns: mismatch: %s", $time, msg);
			errors++;
		endtask

		function void note_request(oal_pkg::req_t r);
			oal_pkg::rsp_t want;
			int            p;
			int            k;
			want = '0;
			p    = int'(r.position);
			case (oal_pkg::req_kind_t'(r.req_type))
				oal_pkg::REQ_INSERT: begin
					if (p >= 1 && p <= len + 1 && len < oal_pkg::LIST_DEPTH) begin
						for (k = len; k >= p; k--)
							store[k] = store[k - 1];
						store[p - 1] = r.value;
						len++;
						want.ok = 1'b1;
					end
				end
				oal_pkg::REQ_DELETE: begin
					if (p >= 1 && p <= len) begin
						for (k = p; k < len; k++)
							store[k - 1] = store[k];
						store[len - 1] = '0;
						len--;
						want.ok = 1'b1;
					end
				end
				oal_pkg::REQ_GET: begin
					if (p >= 1 && p <= len) begin
						want.read_value = store[p - 1];
						want.ok         = 1'b1;
					end
				end
				default: begin
					// Only the live part of the list is searched; first match wins.
					for (k = 0; k < len && !want.ok; k++) begin
						if (store[k] == r.value) begin
							want.found_position = 7'(k + 1);
							want.ok             = 1'b1;
						end
					end
				end
			endcase
			want.list_length = 7'(len);
			expected_q.push_back(want);
		endfunction

		task check_result(oal_pkg::rsp_t got);
			oal_pkg::rsp_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result beat with no request pending (len %0d)",
					got.list_length));
				return;
			end
			want = expected_q.pop_front();
			if (got.ok !== want.ok)
				report($sformatf("ok got %b expected %b", got.ok, want.ok));
			if (got.read_value !== want.read_value)
				report($sformatf("read_value got %h expected %h",
					got.read_value, want.read_value));
			if (got.found_position !== want.found_position)
				report($sformatf("found_position got %0d expected %0d",
					got.found_position, want.found_position));
			if (got.list_length !== want.list_length)
				report($sformatf("list_length got %0d expected %0d",
					got.list_length, want.list_length));
		endtask
	endclass

	list_scoreboard sb;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(rsp);
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic oal_pkg::req_t make_req(oal_pkg::req_kind_t kind, int pos,
		logic [31:0] val);
		oal_pkg::req_t r;
		r.req_type = kind;
		r.position = 7'(pos);
		r.value    = val;
		return r;
	endfunction

	// Valid positions dominate so the list actually grows and shrinks; the rest
	// hit the range edges or anything the field allows.
	function automatic oal_pkg::req_t random_request(int insert_w, int delete_w);
		oal_pkg::req_t r;
		int            roll;
		int            len;
		int            hi;
		int            pos;
		logic [31:0]   val;
		len  = sb.list_len();
		roll = $urandom_range(99);
		if (roll < insert_w)
			r.req_type = oal_pkg::REQ_INSERT;
		else if (roll < insert_w + delete_w)
			r.req_type = oal_pkg::REQ_DELETE;
		else if (roll < insert_w + delete_w + (100 - insert_w - delete_w) / 2)
			r.req_type = oal_pkg::REQ_GET;
		else
			r.req_type = oal_pkg::REQ_LOCATE;

		hi   = (r.req_type == oal_pkg::REQ_INSERT) ? len + 1 : len;
		roll = $urandom_range(99);
		if (roll < 80 && hi >= 1)
			pos = $urandom_range(hi, 1);
		else if (roll < 90) begin
			case ($urandom_range(3))
				0: pos = 0;
				1: pos = hi + 1;
				2: pos = 1;
				default: pos = hi;
			endcase
		end else
			pos = $urandom_range(127, 0);
		r.position = 7'(pos);

		roll = $urandom_range(99);
		if (r.req_type == oal_pkg::REQ_LOCATE && len > 0 && roll < 60)
			val = sb.entry_at($urandom_range(len - 1, 0));
		else if (roll < 40)
			val = 32'($urandom_range(6)) - 32'd3;
		else if (roll < 50) begin
			case ($urandom_range(3))
				0: val = 32'h8000_0000;
				1: val = 32'h7fff_ffff;
				2: val = 32'hffff_ffff;
				default: val = 32'h0;
			endcase
		end else
			val = $urandom;
		r.value = val;
		return r;
	endfunction

	// Present one request beat, hold it until taken, then maybe go idle.
	task automatic send_request(input oal_pkg::req_t r, input int idle_pct);
		int          gap;
		logic [63:0] noise;
		req   <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sb.note_request(r);
		if ($urandom_range(99) < idle_pct) begin
			gap   = $urandom_range(8, 1);
			noise = {$urandom, $urandom};
			start <= 1'b0;
			req   <= noise[$bits(oal_pkg::req_t)-1:0];
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int insert_w [PHASES];
		int delete_w [PHASES];
		int idle_of  [4];
		int phase;
		int n;

		insert_w = '{70, 70, 30, 10, 10, 30, 70, 70, 30, 10, 70, 30};
		delete_w = '{10, 10, 25, 70, 70, 25, 10, 10, 25, 70, 10, 25};
		idle_of  = '{0, 60, 0, 33};

		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list: every request here fails, including out-of-range inserts.
		send_request(make_req(oal_pkg::REQ_GET,    1,   32'h0), 0);
		send_request(make_req(oal_pkg::REQ_DELETE, 1,   32'h0), 0);
		send_request(make_req(oal_pkg::REQ_LOCATE, 0,   32'h0), 0);
		send_request(make_req(oal_pkg::REQ_INSERT, 0,   32'h1), 0);
		send_request(make_req(oal_pkg::REQ_INSERT, 2,   32'h1), 0);
		// Build a short list with the value extremes, front, back and middle.
		send_request(make_req(oal_pkg::REQ_INSERT, 1,   32'h8000_0000), 0);
		send_request(make_req(oal_pkg::REQ_INSERT, 2,   32'h7fff_ffff), 0);
		send_request(make_req(oal_pkg::REQ_INSERT, 1,   32'h0), 0);
		send_request(make_req(oal_pkg::REQ_INSERT, 127, 32'h5), 0);
		send_request(make_req(oal_pkg::REQ_INSERT, 2,   32'hffff_ffff), 0);
		send_request(make_req(oal_pkg::REQ_GET,    1,   32'h0), 0);
		send_request(make_req(oal_pkg::REQ_GET,    4,   32'h0), 0);
		send_request(make_req(oal_pkg::REQ_GET,    5,   32'h0), 0);
		send_request(make_req(oal_pkg::REQ_GET,    127, 32'h0), 0);
		send_request(make_req(oal_pkg::REQ_GET,    0,   32'h0), 0);
		send_request(make_req(oal_pkg::REQ_LOCATE, 0,   32'h7fff_ffff), 0);
		send_request(make_req(oal_pkg::REQ_LOCATE, 0,   32'h0000_3039), 0);
		// A duplicate at the tail; locate must return the first copy.
		send_request(make_req(oal_pkg::REQ_INSERT, 5,   32'hffff_ffff), 0);
		send_request(make_req(oal_pkg::REQ_LOCATE, 0,   32'hffff_ffff), 0);
		send_request(make_req(oal_pkg::REQ_DELETE, 0,   32'h0), 0);
		send_request(make_req(oal_pkg::REQ_DELETE, 6,   32'h0), 0);
		send_request(make_req(oal_pkg::REQ_DELETE, 5,   32'h0), 0);
		send_request(make_req(oal_pkg::REQ_DELETE, 1,   32'h0), 0);
		// The vacated top entry must read as gone and must not match zero.
		send_request(make_req(oal_pkg::REQ_GET,    4,   32'h0), 0);
		send_request(make_req(oal_pkg::REQ_LOCATE, 0,   32'h0), 0);
		drain();

		for (phase = 0; phase < PHASES; phase++) begin
			for (n = 0; n < PHASE_ITEMS; n++)
				send_request(random_request(insert_w[phase], delete_w[phase]),
					idle_of[phase % 4]);
			if (phase % 3 == 2)
				drain();
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[ordered_array_list_top.f]
+incdir+src
src/oal_pkg.sv
src/oal_cell.sv
src/oal_group.sv
src/ordered_array_list_top.sv
sim/tb_ordered_array_list_top.sv
